/* sv/svc_pkg.sv */
// Shared constants, types and the arctangent table for the view cone cull block.
// No dependencies; svc_cordic and sphere_view_cone_cull refer to this package by scoped names.
package svc_pkg;

  localparam int CORDIC_STEPS = 28;

  // Configuration register indexes.
  localparam logic [1:0] CFG_HALF_FOV     = 2'd0;
  localparam logic [1:0] CFG_BOUND_RADIUS = 2'd1;
  localparam logic [1:0] CFG_MIN_DIST_SQ  = 2'd2;

  // Reset values of the configuration registers.
  localparam logic [15:0] HALF_FOV_RST     = 16'd5461;
  localparam logic [31:0] BOUND_RADIUS_RST = 32'd58982;
  localparam logic [31:0] MIN_DIST_SQ_RST  = 32'd5898;

  // Cull reason codes.
  localparam logic [1:0] CULL_NONE  = 2'd0;
  localparam logic [1:0] CULL_DEAD  = 2'd1;
  localparam logic [1:0] CULL_CLOSE = 2'd2;
  localparam logic [1:0] CULL_CONE  = 2'd3;

  // Angles in 2^32 units per turn.
  localparam logic [31:0] QUARTER_TURN       = 32'h4000_0000;
  localparam logic [31:0] THREE_QUARTER_TURN = 32'hC000_0000;

  typedef struct packed {
    logic dead;
    logic close;
    logic in_sphere;
  } svc_flags_t;

  // atan(2^-step) in 2^32 units per turn.
  function automatic logic [31:0] atan_turn(input int step);
    logic [31:0] r;
    case (step)
      0:  r = 32'd536870912;
      1:  r = 32'd316933406;
      2:  r = 32'd167458907;
      3:  r = 32'd85004756;
      4:  r = 32'd42667331;
      5:  r = 32'd21354465;
      6:  r = 32'd10679838;
      7:  r = 32'd5340245;
      8:  r = 32'd2670163;
      9:  r = 32'd1335087;
      10: r = 32'd667544;
      11: r = 32'd333772;
      12: r = 32'd166886;
      13: r = 32'd83443;
      14: r = 32'd41722;
      15: r = 32'd20861;
      16: r = 32'd10430;
      17: r = 32'd5215;
      18: r = 32'd2608;
      19: r = 32'd1304;
      20: r = 32'd652;
      21: r = 32'd326;
      22: r = 32'd163;
      23: r = 32'd81;
      24: r = 32'd41;
      25: r = 32'd20;
      26: r = 32'd10;
      27: r = 32'd5;
      default: r = 32'd0;
    endcase
    return r;
  endfunction

endpackage

/* sv/svc_square.sv */
// Offset and squared distance pipeline: four stages from positions to dx, dy and dx^2+dy^2.
// Depends on nothing but its parameters.
module svc_square #(
  parameter int COORD_BITS = 32,
  parameter int SB         = 1
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        ce,
  input  logic                        in_valid,
  input  logic [COORD_BITS-1:0]       viewer_x,
  input  logic [COORD_BITS-1:0]       viewer_y,
  input  logic [COORD_BITS-1:0]       target_x,
  input  logic [COORD_BITS-1:0]       target_y,
  input  logic [SB-1:0]               in_side,
  output logic                        out_valid,
  output logic signed [COORD_BITS:0]  dx,
  output logic signed [COORD_BITS:0]  dy,
  output logic [2*COORD_BITS+1:0]     d2,
  output logic [SB-1:0]               out_side
);

  localparam int AW  = COORD_BITS + 1;
  localparam int H   = (AW + 1) / 2;
  localparam int HW  = AW - H;
  localparam int D2W = 2 * COORD_BITS + 2;

  logic v1, v2, v3;
  logic signed [AW-1:0] dx1, dy1, dx2, dy2, dx3, dy3;
  logic [AW-1:0] ax2, ay2;
  logic [2*HW-1:0] xhh, yhh;
  logic [HW+H-1:0] xhl, yhl;
  logic [2*H-1:0]  xll, yll;
  logic [SB-1:0] side1, side2, side3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      out_valid <= 1'b0;
    end else if (ce) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      out_valid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      dx1 <= $signed({target_x[COORD_BITS-1], target_x}) - $signed({viewer_x[COORD_BITS-1], viewer_x});
      dy1 <= $signed({target_y[COORD_BITS-1], target_y}) - $signed({viewer_y[COORD_BITS-1], viewer_y});
      side1 <= in_side;

      ax2 <= dx1[AW-1] ? AW'(-dx1) : AW'(dx1);
      ay2 <= dy1[AW-1] ? AW'(-dy1) : AW'(dy1);
      dx2 <= dx1;
      dy2 <= dy1;
      side2 <= side1;

      // Each square is split into high and low halves to keep the multipliers narrow.
      xhh <= ax2[AW-1:H] * ax2[AW-1:H];
      xhl <= ax2[AW-1:H] * ax2[H-1:0];
      xll <= ax2[H-1:0] * ax2[H-1:0];
      yhh <= ay2[AW-1:H] * ay2[AW-1:H];
      yhl <= ay2[AW-1:H] * ay2[H-1:0];
      yll <= ay2[H-1:0] * ay2[H-1:0];
      dx3 <= dx2;
      dy3 <= dy2;
      side3 <= side2;

      d2 <= (D2W'(xhh) << (2 * H)) + (D2W'(xhl) << (H + 1)) + D2W'(xll)
          + (D2W'(yhh) << (2 * H)) + (D2W'(yhl) << (H + 1)) + D2W'(yll);
      dx <= dx3;
      dy <= dy3;
      out_side <= side3;
    end
  end

endmodule

/* sv/svc_isqrt.sv */
// Pipelined integer square root, one result bit per stage, floor(sqrt(n)).
// Depends on nothing but its parameters.
module svc_isqrt #(
  parameter int RW = 33,
  parameter int SB = 1
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            ce,
  input  logic            in_valid,
  input  logic [2*RW-1:0] n,
  input  logic [SB-1:0]   in_side,
  output logic            out_valid,
  output logic [RW-1:0]   root,
  output logic [SB-1:0]   out_side
);

  localparam int NW = 2 * RW;

  logic [NW-1:0] rem_q  [0:RW-1];
  logic [RW-1:0] root_q [0:RW-1];
  logic [SB-1:0] side_q [0:RW-1];
  logic          v_q    [0:RW-1];

  logic [NW-1:0] rem_in  [0:RW-1];
  logic [RW-1:0] root_in [0:RW-1];
  logic [SB-1:0] side_in [0:RW-1];
  logic          v_in    [0:RW-1];
  logic [NW:0]   trial   [0:RW-1];

  always_comb begin
    rem_in[0]  = n;
    root_in[0] = '0;
    side_in[0] = in_side;
    v_in[0]    = in_valid;
    for (int k = 1; k < RW; k++) begin
      rem_in[k]  = rem_q[k-1];
      root_in[k] = root_q[k-1];
      side_in[k] = side_q[k-1];
      v_in[k]    = v_q[k-1];
    end
    // Stage k decides bit RW-1-k: the square grows by 2*r*2^b + 2^(2b).
    for (int k = 0; k < RW; k++) begin
      trial[k] = ((NW+1)'(root_in[k]) << (RW - k)) | ((NW+1)'(1) << (2 * (RW - 1 - k)));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < RW; k++) v_q[k] <= 1'b0;
    end else if (ce) begin
      for (int k = 0; k < RW; k++) v_q[k] <= v_in[k];
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      for (int k = 0; k < RW; k++) begin
        side_q[k] <= side_in[k];
        if ({1'b0, rem_in[k]} >= trial[k]) begin
          rem_q[k]  <= rem_in[k] - trial[k][NW-1:0];
          root_q[k] <= root_in[k] | (RW'(1) << (RW - 1 - k));
        end else begin
          rem_q[k]  <= rem_in[k];
          root_q[k] <= root_in[k];
        end
      end
    end
  end

  assign out_valid = v_q[RW-1];
  assign root      = root_q[RW-1];
  assign out_side  = side_q[RW-1];

endmodule

/* sv/svc_cordic.sv */
// Pipelined vectoring CORDIC giving atan2(y, x) in binary angle units, rounded half up.
// Depends on svc_pkg for the step count and the arctangent table.
module svc_cordic #(
  parameter int CW         = 36,
  parameter int ANGLE_BITS = 16,
  parameter int SB         = 1
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  ce,
  input  logic                  in_valid,
  input  logic signed [CW-1:0]  x,
  input  logic signed [CW-1:0]  y,
  input  logic [SB-1:0]         in_side,
  output logic                  out_valid,
  output logic [ANGLE_BITS-1:0] angle,
  output logic [SB-1:0]         out_side
);

  localparam int N = svc_pkg::CORDIC_STEPS;
  localparam logic [31:0] ROUND = 32'd1 << (31 - ANGLE_BITS);

  logic signed [CW-1:0] xq [0:N];
  logic signed [CW-1:0] yq [0:N];
  logic [31:0]          zq [0:N];
  logic [SB-1:0]        sq [0:N];
  logic                 vq [0:N];
  logic [31:0]          zr;

  assign zr = zq[N] + ROUND;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i <= N; i++) vq[i] <= 1'b0;
      out_valid <= 1'b0;
    end else if (ce) begin
      vq[0] <= in_valid;
      for (int i = 0; i < N; i++) vq[i+1] <= vq[i];
      out_valid <= vq[N];
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      // Vectors in the left half plane are turned by a quarter turn first.
      if (x[CW-1]) begin
        if (!y[CW-1]) begin
          xq[0] <= y;
          yq[0] <= -x;
          zq[0] <= svc_pkg::QUARTER_TURN;
        end else begin
          xq[0] <= -y;
          yq[0] <= x;
          zq[0] <= svc_pkg::THREE_QUARTER_TURN;
        end
      end else begin
        xq[0] <= x;
        yq[0] <= y;
        zq[0] <= '0;
      end
      sq[0] <= in_side;

      // Once y reaches zero the vector stays put for the remaining steps.
      for (int i = 0; i < N; i++) begin
        sq[i+1] <= sq[i];
        if (yq[i] == '0) begin
          xq[i+1] <= xq[i];
          yq[i+1] <= yq[i];
          zq[i+1] <= zq[i];
        end else if (!yq[i][CW-1]) begin
          xq[i+1] <= xq[i] + (yq[i] >>> i);
          yq[i+1] <= yq[i] - (xq[i] >>> i);
          zq[i+1] <= zq[i] + svc_pkg::atan_turn(i);
        end else begin
          xq[i+1] <= xq[i] - (yq[i] >>> i);
          yq[i+1] <= yq[i] + (xq[i] >>> i);
          zq[i+1] <= zq[i] - svc_pkg::atan_turn(i);
        end
      end

      angle    <= zr[31:32-ANGLE_BITS];
      out_side <= sq[N];
    end
  end

endmodule

/* sv/svc_skid.sv */
// Two-entry output buffer: a result register plus one holding slot, registered ready.
// Depends on nothing but its parameter.
module svc_skid #(
  parameter int DW = 8
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [DW-1:0] in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [DW-1:0] out_data
);

  logic          hold_valid;
  logic [DW-1:0] hold_data;
  logic          take_in;

  assign in_ready = !hold_valid;
  assign take_in  = in_valid && !hold_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      hold_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      out_valid  <= hold_valid || take_in;
      hold_valid <= 1'b0;
    end else if (take_in) begin
      hold_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || out_ready) begin
      out_data <= hold_valid ? hold_data : in_data;
    end else if (take_in) begin
      hold_data <= in_data;
    end
  end

endmodule

/* sv/sphere_view_cone_cull.sv */
// Pipeline from input accept to result valid: 4 distance stages, 1 compare stage,
// COORD_BITS + 1 square root stages, 30 CORDIC stages and the output register. One item
// per cycle sustained unless the output slot is full; both CORDICs run side by side.
// Reset (rst, synchronous) empties the pipeline and loads the configuration defaults.
// Uses svc_pkg, svc_square, svc_isqrt, svc_cordic and svc_skid.
module sphere_view_cone_cull #(
  parameter int ANGLE_BITS = 16,
  parameter int COORD_BITS = 32
) (
  input  logic clk,
  input  logic rst,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  // viewer_x, viewer_y, viewer_angle, target_x, target_y, zero fill
  input  logic [((4*COORD_BITS+ANGLE_BITS+7)/8)*8-1:0] s_axis_tdata,
  // target_dead
  input  logic s_axis_tuser,
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  // visible, cull_reason, zero fill
  output logic [7:0] m_axis_tdata,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int W   = COORD_BITS;
  localparam int A   = ANGLE_BITS;
  localparam int D2W = 2 * W + 2;
  localparam int RW  = W + 1;
  localparam int EW  = (D2W > 64) ? D2W : 64;
  localparam int MW  = (W > 32) ? W : 32;
  localparam int CW  = ((W > 32) ? W : 32) + 4;
  localparam int LW  = ((A > 16) ? A : 16) + 1;
  localparam int ISB = 2 * (W + 1) + A + 3;
  localparam logic [A-1:0] HALF_TURN = A'(1) << (A - 1);

  logic [15:0] half_fov;
  logic [31:0] bound_radius;
  logic [31:0] min_dist_sq;
  logic [63:0] r2;
  logic        ce;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      half_fov     <= svc_pkg::HALF_FOV_RST;
      bound_radius <= svc_pkg::BOUND_RADIUS_RST;
      min_dist_sq  <= svc_pkg::MIN_DIST_SQ_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        svc_pkg::CFG_HALF_FOV:     half_fov     <= cfg_data[15:0];
        svc_pkg::CFG_BOUND_RADIUS: bound_radius <= cfg_data;
        svc_pkg::CFG_MIN_DIST_SQ:  min_dist_sq  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    r2 <= bound_radius * bound_radius;
  end

  // Offsets and squared distance.
  logic                sq_valid;
  logic signed [W:0]   sq_dx, sq_dy;
  logic [D2W-1:0]      d2;
  logic [A:0]          sq_side;

  svc_square #(.COORD_BITS(W), .SB(A + 1)) u_square (
    .clk(clk), .rst(rst), .ce(ce), .in_valid(s_axis_tvalid && s_axis_tready),
    .viewer_x(s_axis_tdata[W-1:0]),
    .viewer_y(s_axis_tdata[2*W-1:W]),
    .target_x(s_axis_tdata[3*W+A-1:2*W+A]),
    .target_y(s_axis_tdata[4*W+A-1:3*W+A]),
    .in_side({s_axis_tuser, s_axis_tdata[2*W+A-1:2*W]}),
    .out_valid(sq_valid), .dx(sq_dx), .dy(sq_dy), .d2(d2), .out_side(sq_side)
  );

  // Distance checks and d^2 - r^2 for the angular radius.
  logic [W-1:0]  dsq;
  logic          close_c, inside_c;
  logic [EW-1:0] q_c;

  always_comb begin
    if (|d2[D2W-1:W+16]) dsq = '1;
    else dsq = d2[W+15:16];
    close_c  = MW'(dsq) < MW'(min_dist_sq);
    inside_c = EW'(d2) < EW'(r2);
    q_c      = EW'(d2) - EW'(r2);
  end

  logic                v5;
  logic [D2W-1:0]      q5;
  logic signed [W:0]   dx5, dy5;
  logic [A-1:0]        va5;
  svc_pkg::svc_flags_t flags5;

  always_ff @(posedge clk) begin
    if (rst) v5 <= 1'b0;
    else if (ce) v5 <= sq_valid;
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      q5               <= q_c[D2W-1:0];
      dx5              <= sq_dx;
      dy5              <= sq_dy;
      va5              <= sq_side[A-1:0];
      flags5.dead      <= sq_side[A];
      flags5.close     <= close_c;
      flags5.in_sphere <= inside_c;
    end
  end

  // Square root of d^2 - r^2, with the rest of the item riding alongside.
  logic                rt_valid;
  logic [RW-1:0]       rt_root;
  logic [ISB-1:0]      rt_side;
  logic signed [W:0]   rt_dx, rt_dy;
  logic [A-1:0]        rt_va;
  svc_pkg::svc_flags_t rt_flags;

  svc_isqrt #(.RW(RW), .SB(ISB)) u_isqrt (
    .clk(clk), .rst(rst), .ce(ce), .in_valid(v5), .n(q5),
    .in_side({dx5, dy5, va5, flags5}),
    .out_valid(rt_valid), .root(rt_root), .out_side(rt_side)
  );

  assign {rt_dx, rt_dy, rt_va, rt_flags} = rt_side;

  // Angular radius atan2(r, s) and bearing atan2(dx, dy), in lockstep.
  logic                ang_valid, brg_valid;
  logic [A-1:0]        ang, bearing, va_f;
  svc_pkg::svc_flags_t flags_f;

  svc_cordic #(.CW(CW), .ANGLE_BITS(A), .SB(3)) u_cordic_radius (
    .clk(clk), .rst(rst), .ce(ce), .in_valid(rt_valid),
    .x($signed(CW'(rt_root))), .y($signed(CW'(bound_radius))),
    .in_side(rt_flags),
    .out_valid(ang_valid), .angle(ang), .out_side(flags_f)
  );

  svc_cordic #(.CW(CW), .ANGLE_BITS(A), .SB(A)) u_cordic_bearing (
    .clk(clk), .rst(rst), .ce(ce), .in_valid(rt_valid),
    .x(CW'(rt_dy)), .y(CW'(rt_dx)),
    .in_side(rt_va),
    .out_valid(brg_valid), .angle(bearing), .out_side(va_f)
  );

  // Cone test and reason.
  logic [A-1:0]  diff, mag;
  logic [LW-1:0] limit;
  logic [1:0]    reason;

  always_comb begin
    diff  = bearing - va_f;
    mag   = (diff > HALF_TURN) ? A'(-diff) : diff;
    limit = LW'(half_fov) + LW'(ang);
    if (flags_f.dead) reason = svc_pkg::CULL_DEAD;
    else if (flags_f.close) reason = svc_pkg::CULL_CLOSE;
    else if (flags_f.in_sphere) reason = svc_pkg::CULL_NONE;
    else if (LW'(mag) <= limit) reason = svc_pkg::CULL_NONE;
    else reason = svc_pkg::CULL_CONE;
  end

  svc_skid #(.DW(8)) u_skid (
    .clk(clk), .rst(rst),
    .in_valid(ang_valid), .in_ready(ce),
    .in_data({5'b0, reason, reason == svc_pkg::CULL_NONE}),
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .out_data(m_axis_tdata)
  );

  assign s_axis_tready = ce;

  a_visible_matches_reason: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[0] == (m_axis_tdata[2:1] == svc_pkg::CULL_NONE)))
    else $error("visible flag disagrees with cull reason");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> m_axis_tvalid)
    else $error("input stalled while no result is waiting");

  a_cordic_lockstep: assert property (@(posedge clk) disable iff (rst)
    ang_valid == brg_valid)
    else $error("radius and bearing pipelines out of step");

  a_reset_empties: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid && s_axis_tready)
    else $error("output not empty after reset");

endmodule
